>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/slt_pkg.sv
package slt_pkg;

    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int FOUND_INDEX_W = 4;
    localparam int COUNT_W       = 5;
    localparam int SUM_W         = 36;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BELOW  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new item and set up the scan
        logic rd;     // issue a table read at the current scan position
        logic eval;   // act on the read data and advance the scan
        logic fin;    // commit the item and present its result
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stop;   // scan is over: nothing left to read or the item resolved early
    } t_dp_stat;

endpackage

>>> rtl/slt_ctrl.sv
module slt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  slt_pkg::t_dp_stat i_stat,
    output slt_pkg::t_dp_ctrl o_ctrl,
    output logic              busy
);
    import slt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.stop) begin
                    o_ctrl.fin = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_ctrl.rd = 1'b1;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                o_ctrl.eval = 1'b1;
                n_state     = S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> rtl/slt_datapath.sv
module slt_datapath #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [slt_pkg::CMD_W-1:0]            i_command,
    input  logic signed [VALUE_WIDTH-1:0]        i_value,
    input  slt_pkg::t_dp_ctrl                    i_ctrl,
    output slt_pkg::t_dp_stat                    o_stat,
    output logic                                 o_valid,
    output logic [slt_pkg::STATUS_W-1:0]         o_status,
    output logic [slt_pkg::FOUND_INDEX_W-1:0]    o_found_index,
    output logic [slt_pkg::COUNT_W-1:0]          o_count_below,
    output logic [slt_pkg::COUNT_W-1:0]          o_entry_count,
    output logic signed [slt_pkg::SUM_W-1:0]     o_total_sum
);
    import slt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [CMD_W-1:0]              r_cmd;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] r_rdata;
    logic [CNT_W-1:0]              r_count;
    logic [SUM_W-1:0]              r_sum;
    logic [CNT_W-1:0]              r_left;
    logic [IDX_W-1:0]              r_ptr;
    logic                          r_done;
    logic                          r_found;
    logic [CNT_W-1:0]              r_below;
    logic [IDX_W-1:0]              r_hit_idx;
    logic                          r_valid;
    logic [STATUS_W-1:0]           r_status;
    logic [FOUND_INDEX_W-1:0]      r_found_index;
    logic [COUNT_W-1:0]            r_count_below;

    logic                          is_ins;
    logic                          is_rem;
    logic                          is_srch;
    logic                          is_below;
    logic                          full;
    logic                          d_lt;
    logic                          d_eq;
    logic [CNT_W-1:0]              left_m1;
    logic [IDX_W-1:0]              ptr_m1;
    logic [IDX_W-1:0]              rd_addr;
    logic signed [EXT_W-1:0]       v_ext;
    logic [SUM_W-1:0]              v_sum;
    logic                          we;
    logic [IDX_W-1:0]              waddr;
    logic [VALUE_WIDTH-1:0]        wdata;

    assign is_ins   = (r_cmd == CMD_INSERT);
    assign is_rem   = (r_cmd == CMD_REMOVE);
    assign is_srch  = (r_cmd == CMD_SEARCH);
    assign is_below = (r_cmd == CMD_BELOW);
    assign full     = (r_count == CNT_W'(DEPTH));
    assign d_lt     = (r_rdata < r_value);
    assign d_eq     = (r_rdata == r_value);
    assign left_m1  = r_left - 1'b1;
    assign ptr_m1   = r_ptr - 1'b1;
    // insert walks down from the top entry, the other commands walk up from zero
    assign rd_addr  = is_ins ? left_m1[IDX_W-1:0] : r_ptr;
    assign v_ext    = EXT_W'(r_value);
    assign v_sum    = v_ext[SUM_W-1:0];

    assign o_stat.stop = (r_left == '0) || r_done;

    always_comb begin
        we    = 1'b0;
        waddr = r_left[IDX_W-1:0];
        wdata = r_rdata;
        if (i_ctrl.eval) begin
            if (is_ins && !d_lt) begin
                // shift an entry that is not smaller up by one
                we = 1'b1;
            end else if (is_rem && r_found) begin
                // close the gap behind the removed entry
                we    = 1'b1;
                waddr = ptr_m1;
            end
        end else if (i_ctrl.fin && is_ins && !full) begin
            we    = 1'b1;
            wdata = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_ctrl.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd     <= i_command;
            r_value   <= i_value;
            r_left    <= ((i_command == CMD_INSERT) && full) ? '0 : r_count;
            r_ptr     <= '0;
            r_done    <= 1'b0;
            r_found   <= 1'b0;
            r_below   <= '0;
            r_hit_idx <= '0;
        end else if (i_ctrl.eval) begin
            if (is_ins) begin
                if (d_lt) begin
                    r_done <= 1'b1;
                end else begin
                    r_left <= left_m1;
                end
            end else if (is_srch && d_eq) begin
                r_found   <= 1'b1;
                r_done    <= 1'b1;
                r_hit_idx <= r_ptr;
            end else begin
                if (is_rem && d_eq) begin
                    r_found <= 1'b1;
                end
                if (is_below && d_lt) begin
                    r_below <= r_below + 1'b1;
                end
                r_ptr  <= r_ptr + 1'b1;
                r_left <= left_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin) begin
            r_found_index <= '0;
            r_count_below <= '0;
            case (r_cmd)
                CMD_INSERT: begin
                    r_status <= full ? STATUS_FULL : STATUS_OK;
                end
                CMD_REMOVE: begin
                    r_status <= r_found ? STATUS_OK : STATUS_NOT_FOUND;
                end
                CMD_SEARCH: begin
                    r_status <= r_found ? STATUS_OK : STATUS_NOT_FOUND;
                    if (r_found) begin
                        r_found_index <= FOUND_INDEX_W'(r_hit_idx);
                    end
                end
                default: begin
                    r_status      <= STATUS_OK;
                    r_count_below <= COUNT_W'(r_below);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.fin;
            if (i_ctrl.fin) begin
                if (is_ins && !full) begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + v_sum;
                end else if (is_rem && r_found) begin
                    r_count <= r_count - 1'b1;
                    r_sum   <= r_sum - v_sum;
                end
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found_index;
    assign o_count_below = r_count_below;
    assign o_entry_count = COUNT_W'(r_count);
    assign o_total_sum   = r_sum;

endmodule

>>> rtl/sorted_list_table.sv
// Sorted table of signed values, kept in ascending order in a single-port
// style table memory (one write, one registered read per cycle).
// Issue an item by raising start with command and value while busy is low;
// the item is taken at that clock edge and busy rises on the next cycle.
// Commands: insert in order, remove first match, search, count entries below.
// The result comes back on the o_ ports for exactly one cycle, marked by
// o_valid; the receiver must take it then, it cannot stall the block.
// The scan reads at most the entry count of entries, one at a time: each entry
// is first read from the table port, then compared and, where needed, shifted;
// insert scans down from the top and stops at the first smaller entry,
// search stops at the first match, remove and count-below read every entry.
// A new item is taken only when the previous one has finished and busy is low.
// o_entry_count and o_total_sum always show the current table state.
// Reset empties the table and clears the sum; no clearing pass is needed,
// since only positions below the entry count are ever read.
module sorted_list_table #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [slt_pkg::CMD_W-1:0]            i_command,
    input  logic signed [VALUE_WIDTH-1:0]        i_value,
    output logic                                 o_valid,
    output logic [slt_pkg::STATUS_W-1:0]         o_status,
    output logic [slt_pkg::FOUND_INDEX_W-1:0]    o_found_index,
    output logic [slt_pkg::COUNT_W-1:0]          o_count_below,
    output logic [slt_pkg::COUNT_W-1:0]          o_entry_count,
    output logic signed [slt_pkg::SUM_W-1:0]     o_total_sum
);
    import slt_pkg::*;

    `include "assert_macros.svh"

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    slt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    slt_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_count_below (o_count_below),
        .o_entry_count (o_entry_count),
        .o_total_sum   (o_total_sum)
    );

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_fin_strobe, i_clk, i_rst_n, ctrl.fin, o_valid && !busy)
    `ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_valid && (o_status == STATUS_FULL), o_entry_count == FULL_COUNT)

endmodule

>>> verif/testbench.sv
module testbench;
    import slt_pkg::*;

    localparam int DEPTH          = 16;
    localparam int VW             = 32;
    localparam int NUM_RANDOM     = 1400;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_mode_t;

    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic signed [VW-1:0] value;
        int unsigned          gap;
        bit                   wait_empty;
    } table_op_t;

    typedef struct {
        logic [STATUS_W-1:0]        status;
        logic [FOUND_INDEX_W-1:0]   found_index;
        logic [COUNT_W-1:0]         count_below;
        logic [COUNT_W-1:0]         entry_count;
        logic signed [SUM_W-1:0]    total_sum;
    } table_result_t;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       start     = 1'b0;
    logic [CMD_W-1:0]           i_command = CMD_INSERT;
    logic signed [VW-1:0]       i_value   = '0;
    logic                       busy;
    logic                       o_valid;
    logic [STATUS_W-1:0]        o_status;
    logic [FOUND_INDEX_W-1:0]   o_found_index;
    logic [COUNT_W-1:0]         o_count_below;
    logic [COUNT_W-1:0]         o_entry_count;
    logic signed [SUM_W-1:0]    o_total_sum;

    sorted_list_table #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_count_below (o_count_below),
        .o_entry_count (o_entry_count),
        .o_total_sum   (o_total_sum)
    );

    always #5 i_clk = ~i_clk;

    // Predicted table contents, kept in ascending order
    logic signed [VW-1:0]    sorted_vals [DEPTH];
    int unsigned             held_vals = 0;
    logic signed [SUM_W-1:0] held_sum  = '0;

    table_op_t            op_queue[$];
    table_result_t        pending_results[$];
    logic signed [VW-1:0] gen_contents[$];   // unordered view used only to aim removes/searches
    logic signed [VW-1:0] hot_pool [6];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int full_seen     = 0;
    int miss_seen     = 0;
    int peak_entries  = 0;
    int idle_cycles   = 0;
    int gap_cnt       = 0;

    function automatic table_result_t apply_table_op(logic [CMD_W-1:0] cmd,
                                                     logic signed [VW-1:0] v);
        table_result_t r;
        int unsigned   pos;
        int unsigned   hit;
        r.status      = STATUS_OK;
        r.found_index = '0;
        r.count_below = '0;
        hit = 0;
        while (hit < held_vals && sorted_vals[hit] != v) hit++;
        case (cmd)
            CMD_INSERT: begin
                if (held_vals >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_vals && sorted_vals[pos] < v) pos++;
                    for (int i = held_vals; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
                    sorted_vals[pos] = v;
                    held_vals++;
                    held_sum = held_sum + {{(SUM_W-VW){v[VW-1]}}, v};
                end
            end
            CMD_REMOVE: begin
                if (hit == held_vals) begin
                    r.status = STATUS_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < held_vals; i++) sorted_vals[i] = sorted_vals[i+1];
                    held_vals--;
                    held_sum = held_sum - {{(SUM_W-VW){v[VW-1]}}, v};
                end
            end
            CMD_SEARCH: begin
                if (hit == held_vals) r.status = STATUS_NOT_FOUND;
                else r.found_index = FOUND_INDEX_W'(hit);
            end
            default: begin
                for (int i = 0; i < held_vals; i++)
                    if (sorted_vals[i] < v) r.count_below++;
            end
        endcase
        r.entry_count = COUNT_W'(held_vals);
        r.total_sum   = held_sum;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t result #%0d: %s", $time, results_seen, msg);
        errors++;
    endtask

    task automatic add_op(input logic [CMD_W-1:0] cmd, input logic signed [VW-1:0] value,
                          input int unsigned gap, input bit wait_empty);
        table_op_t op;
        op.cmd        = cmd;
        op.value      = value;
        op.gap        = gap;
        op.wait_empty = wait_empty;
        op_queue.push_back(op);
        if (cmd == CMD_INSERT && gen_contents.size() < DEPTH) begin
            gen_contents.push_back(value);
        end else if (cmd == CMD_REMOVE) begin
            foreach (gen_contents[i]) begin
                if (gen_contents[i] == value) begin
                    gen_contents.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        logic signed [VW-1:0] v;
        int unsigned r;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 40) begin
            v = hot_pool[$urandom_range(0, 5)];
        end else if (r < 55) begin
            case ($urandom_range(0, 5))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = '0;
                3: v = -1;
                4: v = VAL_MIN + 1;
                default: v = VAL_MAX - 1;
            endcase
        end
        return v;
    endfunction

    // Driver: hold an item until taken, then wait out the next item's gap
    always @(posedge i_clk) begin : driver
        bit        take;
        bit        next_start;
        table_op_t op;
        take = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start && !take;
            if (take) begin
                pending_results.push_back(apply_table_op(i_command, i_value));
                items_sent++;
            end
            if (!next_start && op_queue.size() > 0) begin
                if (op_queue[0].wait_empty && pending_results.size() > 0) begin
                    // hold until every outstanding result is back
                end else if (gap_cnt < op_queue[0].gap) begin
                    gap_cnt++;
                end else begin
                    op = op_queue.pop_front();
                    i_command  <= op.cmd;
                    i_value    <= op.value;
                    next_start = 1'b1;
                    gap_cnt    = 0;
                end
            end
            start <= next_start;
        end
    end

    // Monitor and watchdog
    always @(posedge i_clk) begin : monitor
        table_result_t want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no item or result moved for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else if (o_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                    if (o_found_index !== want.found_index)
                        report_mismatch($sformatf("found_index %0d, want %0d",
                                                  o_found_index, want.found_index));
                    if (o_count_below !== want.count_below)
                        report_mismatch($sformatf("count_below %0d, want %0d",
                                                  o_count_below, want.count_below));
                    if (o_entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, want %0d",
                                                  o_entry_count, want.entry_count));
                    if (o_total_sum !== want.total_sum)
                        report_mismatch($sformatf("total_sum %0d, want %0d",
                                                  o_total_sum, want.total_sum));
                    if (want.status == STATUS_FULL) full_seen++;
                    if (want.status == STATUS_NOT_FOUND) miss_seen++;
                    if (want.entry_count > peak_entries) peak_entries = want.entry_count;
                end
                results_seen++;
            end
        end
    end

    initial begin : stimulus
        mix_mode_t            mode;
        logic [CMD_W-1:0]     cmd;
        logic signed [VW-1:0] value;
        int unsigned          r;
        int unsigned          len;
        int                   n_random;
        bit                   no_gaps;
        bit                   first;

        // Directed: empty table, extremes, duplicates, misses
        add_op(CMD_SEARCH, '0,          0, 1'b0);
        add_op(CMD_REMOVE, 123,         0, 1'b0);
        add_op(CMD_BELOW,  VAL_MIN,     2, 1'b0);
        add_op(CMD_INSERT, VAL_MAX,     0, 1'b0);
        add_op(CMD_INSERT, VAL_MIN,     0, 1'b0);
        add_op(CMD_INSERT, '0,          1, 1'b0);
        add_op(CMD_INSERT, '0,          0, 1'b0);
        add_op(CMD_INSERT, -1,          0, 1'b0);
        add_op(CMD_SEARCH, '0,          0, 1'b0);
        add_op(CMD_BELOW,  '0,          3, 1'b0);
        add_op(CMD_BELOW,  VAL_MAX,     0, 1'b0);
        add_op(CMD_BELOW,  VAL_MIN,     0, 1'b0);
        add_op(CMD_SEARCH, VAL_MIN,     0, 1'b0);
        add_op(CMD_SEARCH, VAL_MAX,     7, 1'b0);
        add_op(CMD_REMOVE, '0,          0, 1'b0);
        add_op(CMD_REMOVE, 7,           0, 1'b0);
        add_op(CMD_INSERT, 32'h5555_5555, 0, 1'b0);
        add_op(CMD_INSERT, 32'hAAAA_AAAA, 0, 1'b0);
        add_op(CMD_REMOVE, VAL_MIN,     0, 1'b0);
        add_op(CMD_REMOVE, VAL_MAX,     0, 1'b0);
        add_op(CMD_BELOW,  1,           0, 1'b1);

        // Random: episodes biased to fill, drain or mix the table
        n_random = 0;
        first    = 1'b1;
        while (n_random < NUM_RANDOM) begin
            mode    = first ? MIX_FILL : mix_mode_t'($urandom_range(0, 2));
            len     = first ? 40 : $urandom_range(10, 60);
            no_gaps = ($urandom_range(0, 9) < 3);
            foreach (hot_pool[i])
                hot_pool[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, 40) - 20;
            repeat (len) begin
                r = $urandom_range(0, 99);
                case (mode)
                    MIX_FILL:  cmd = (r < 70) ? CMD_INSERT : (r < 78) ? CMD_REMOVE :
                                     (r < 89) ? CMD_SEARCH : CMD_BELOW;
                    MIX_DRAIN: cmd = (r < 15) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
                                     (r < 85) ? CMD_SEARCH : CMD_BELOW;
                    default:   cmd = (r < 25) ? CMD_INSERT : (r < 50) ? CMD_REMOVE :
                                     (r < 75) ? CMD_SEARCH : CMD_BELOW;
                endcase
                if ((cmd == CMD_REMOVE || cmd == CMD_SEARCH) && gen_contents.size() > 0
                    && $urandom_range(0, 1))
                    value = gen_contents[$urandom_range(0, gen_contents.size() - 1)];
                else
                    value = pick_value();
                add_op(cmd, value, no_gaps ? 0 : $urandom_range(0, 7),
                       first || ($urandom_range(0, 199) == 0));
                first = 1'b0;
                n_random++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || start || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d table operations and %0d results: %0d full-table inserts, %0d misses.",
                 items_sent, results_seen, full_seen, miss_seen);
        $display("Table reached %0d of %0d entries; %0d mismatches.",
                 peak_entries, DEPTH, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_ctrl.sv
rtl/slt_datapath.sv
rtl/sorted_list_table.sv
verif/testbench.sv
